FILE: rtl/cov_pkg.sv
// Shared types, codes and constants of the cursor overlay compositor.
`timescale 1ns / 1ps
`default_nettype none
package cov_pkg;

  localparam int unsigned SHAPE_WORDS_DEF = 4096;
  localparam int unsigned CFG_DW = 14;
  localparam int unsigned CFG_IW = 3;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_PIXEL = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BOX   = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOFRAME = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CT_MONO   = 2'd0,
    CT_ALPHA  = 2'd1,
    CT_MASKED = 2'd2,
    CT_PASS   = 2'd3
  } ctype_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_ROTATION     = 3'd0,
    REG_CURSOR_TYPE  = 3'd1,
    REG_CURSOR_WIDTH = 3'd2,
    REG_SHAPE_HEIGHT = 3'd3,
    REG_SHAPE_PITCH  = 3'd4,
    REG_SCREEN_WIDTH = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6
  } reg_e;

  typedef struct packed {
    rot_e        rotation;
    ctype_e      cursor_type;
    logic [8:0]  cursor_width;
    logic [9:0]  shape_height;
    logic [10:0] shape_pitch;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [12:0] box_left;
    logic [12:0] box_top;
    logic [13:0] box_width;
    logic [13:0] box_height;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t               res;
    logic               compose;
    logic [31:0]        desk;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic               wr;
    logic [11:0]        waddr;
    logic [31:0]        wdata;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/cov_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cov_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cov_frame.sv
// Input register, frame setup with box clipping, raster counters and cursor coordinates.
`timescale 1ns / 1ps
`default_nettype none
module cov_frame import cov_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire action_e            action_i,
  input  wire logic [11:0]        shape_addr_i,
  input  wire logic [31:0]        shape_data_i,
  input  wire logic signed [13:0] pointer_x_i,
  input  wire logic signed [13:0] pointer_y_i,
  input  wire logic [31:0]        desktop_pixel_i,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output item_t                   m_item_o
);

  logic               v1_q, v2_q;
  action_e            act1_q;
  logic [11:0]        addr1_q;
  logic [31:0]        data1_q, desk1_q;
  logic signed [13:0] px1_q, py1_q;
  item_t              item_d, item2_q;
  logic               en2, fire1;

  logic [13:0] col_q, row_q, region_w_q, region_h_q;
  logic [9:0]  skip_cols_q, skip_rows_q;
  logic        active_q;

  logic [9:0]         ch;
  logic signed [17:0] cw_s, ch_s, capw, caph, dw, dh, pxs, pys, dx, dy;
  logic signed [17:0] rgt, bot, lc, tc, rc, bc, bw, bh, ox, oy, cx, cy;
  logic               empty, wrap_col, wrap_row;
  logic [13:0]        col_n, row_n;

  assign en2       = !v2_q || m_ready_i;
  assign s_ready_o = !v1_q || en2;
  assign fire1     = v1_q && en2;
  assign m_valid_o = v2_q;
  assign m_item_o  = item2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s_ready_o) v1_q <= s_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      act1_q  <= action_i;
      addr1_q <= shape_addr_i;
      data1_q <= shape_data_i;
      px1_q   <= pointer_x_i;
      py1_q   <= pointer_y_i;
      desk1_q <= desktop_pixel_i;
    end
    if (fire1) item2_q <= item_d;
  end

  // Box placement in the landscape desktop image and its clip to the screen.
  always_comb begin
    ch   = (cfg_i.cursor_type == CT_MONO) ? {1'b0, cfg_i.shape_height[9:1]}
                                          : cfg_i.shape_height;
    cw_s = 18'({1'b0, cfg_i.cursor_width});
    ch_s = 18'({1'b0, ch});
    capw = cfg_i.rotation[0] ? ch_s : cw_s;
    caph = cfg_i.rotation[0] ? cw_s : ch_s;
    dw   = 18'({1'b0, cfg_i.rotation[0] ? cfg_i.screen_height : cfg_i.screen_width});
    dh   = 18'({1'b0, cfg_i.rotation[0] ? cfg_i.screen_width : cfg_i.screen_height});
    pxs  = 18'(px1_q);
    pys  = 18'(py1_q);
    unique case (cfg_i.rotation)
      ROT_90: begin
        dx = pys;
        dy = dh - 18'sd1 - pxs - cw_s;
      end
      ROT_180: begin
        dx = dw - 18'sd1 - pxs - cw_s;
        dy = dh - 18'sd1 - pys - ch_s;
      end
      ROT_270: begin
        dx = dw - 18'sd1 - pys - ch_s;
        dy = pxs;
      end
      default: begin
        dx = pxs;
        dy = pys;
      end
    endcase
    rgt   = dx + capw;
    bot   = dy + caph;
    lc    = (dx < 18'sd0) ? 18'sd0 : dx;
    tc    = (dy < 18'sd0) ? 18'sd0 : dy;
    rc    = (rgt > dw) ? dw : rgt;
    bc    = (bot > dh) ? dh : bot;
    bw    = rc - lc;
    bh    = bc - tc;
    empty = (bw <= 18'sd0) || (bh <= 18'sd0);
  end

  // Shape coordinates of the current pixel.
  always_comb begin
    ox = $signed({4'b0, col_q}) + $signed({8'b0, skip_cols_q});
    oy = $signed({4'b0, row_q}) + $signed({8'b0, skip_rows_q});
    unique case (cfg_i.rotation)
      ROT_90: begin
        cx = cw_s - 18'sd1 - oy;
        cy = ox;
      end
      ROT_180: begin
        cx = cw_s - 18'sd1 - ox;
        cy = ch_s - 18'sd1 - oy;
      end
      ROT_270: begin
        cx = oy;
        cy = ch_s - 18'sd1 - ox;
      end
      default: begin
        cx = ox;
        cy = oy;
      end
    endcase
    col_n    = col_q + 14'd1;
    row_n    = row_q + 14'd1;
    wrap_col = col_n >= region_w_q;
    wrap_row = row_n >= region_h_q;
  end

  always_comb begin
    item_d       = '0;
    item_d.desk  = desk1_q;
    item_d.cx    = cx;
    item_d.cy    = cy;
    item_d.waddr = addr1_q;
    item_d.wdata = data1_q;
    unique case (act1_q)
      ACT_LOAD: begin
        item_d.res.kind = KIND_LOAD;
        item_d.wr       = 1'b1;
      end
      ACT_FRAME: begin
        item_d.res.kind = KIND_BOX;
        if (empty) begin
          item_d.res.status = ST_EMPTY;
        end else begin
          item_d.res.box_left   = lc[12:0];
          item_d.res.box_top    = tc[12:0];
          item_d.res.box_width  = bw[13:0];
          item_d.res.box_height = bh[13:0];
        end
      end
      ACT_PIXEL: begin
        item_d.res.kind = KIND_PIXEL;
        if (active_q) begin
          item_d.compose  = 1'b1;
          item_d.res.last = wrap_col && wrap_row;
        end else begin
          item_d.res.status = ST_NOFRAME;
        end
      end
      default: item_d.res.kind = KIND_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      region_w_q  <= '0;
      region_h_q  <= '0;
      skip_cols_q <= '0;
      skip_rows_q <= '0;
      active_q    <= 1'b0;
    end else if (fire1) begin
      unique case (act1_q)
        ACT_FRAME: begin
          col_q    <= '0;
          row_q    <= '0;
          active_q <= !empty;
          if (empty) begin
            region_w_q  <= '0;
            region_h_q  <= '0;
            skip_cols_q <= '0;
            skip_rows_q <= '0;
          end else begin
            region_w_q  <= bw[13:0];
            region_h_q  <= bh[13:0];
            skip_cols_q <= (dx < 18'sd0) ? 10'(-dx) : 10'd0;
            skip_rows_q <= (dy < 18'sd0) ? 10'(-dy) : 10'd0;
          end
        end
        ACT_PIXEL: begin
          if (active_q) begin
            if (wrap_col) begin
              col_q <= '0;
              if (wrap_row) begin
                row_q    <= '0;
                active_q <= 1'b0;
              end else begin
                row_q <= row_n;
              end
            end else begin
              col_q <= col_n;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cov_addr.sv
// Shape address generation and the shape store read.
`timescale 1ns / 1ps
`default_nettype none
module cov_addr import cov_pkg::*; #(
  parameter int unsigned SHAPE_WORDS = SHAPE_WORDS_DEF,
  localparam int unsigned AW = $clog2(SHAPE_WORDS)
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  s_valid_i,
  output logic       s_ready_o,
  input  wire item_t s_item_i,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output item_t      m_item_o,
  output logic [1:0] m_lane_a_o,
  output logic [1:0] m_lane_b_o,
  output logic [2:0] m_bit_o,
  output logic [31:0] m_word_a_o,
  output logic [31:0] m_word_b_o
);

  logic               v3_q, v4_q, en3, en4, fire3, mono;
  item_t              item3_q, item4_q;
  logic signed [30:0] pa_d, pb_d, pa3_q, pb3_q;
  logic signed [17:0] cxq_d, cxq3_q, cyb;
  logic signed [12:0] mul_k, pitch_s;
  logic [9:0]         ch;
  logic signed [31:0] ba, bb, wsum;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic [1:0]         lane_a4_q, lane_b4_q;
  logic [2:0]         bit4_q;

  assign mono      = cfg_i.cursor_type == CT_MONO;
  assign en4       = !v4_q || m_ready_i;
  assign en3       = !v3_q || en4;
  assign fire3     = v3_q && en4;
  assign s_ready_o = en3;
  assign m_valid_o = v4_q;
  assign m_item_o  = item4_q;
  assign m_lane_a_o = lane_a4_q;
  assign m_lane_b_o = lane_b4_q;
  assign m_bit_o    = bit4_q;

  // Row offsets; the xor mask sits one image height below the and mask.
  always_comb begin
    ch      = mono ? {1'b0, cfg_i.shape_height[9:1]} : cfg_i.shape_height;
    pitch_s = $signed({2'b0, cfg_i.shape_pitch});
    mul_k   = mono ? pitch_s : $signed({4'b0, cfg_i.cursor_width});
    cyb     = s_item_i.cy + $signed({8'b0, ch});
    pa_d    = 31'(s_item_i.cy * mul_k);
    pb_d    = 31'(cyb * pitch_s);
    // Byte column, truncated toward zero.
    cxq_d   = (s_item_i.cx >>> 3) +
              ((s_item_i.cx < 18'sd0 && s_item_i.cx[2:0] != 3'd0) ? 18'sd1 : 18'sd0);
  end

  always_comb begin
    ba      = 32'(cxq3_q) + 32'(pa3_q);
    bb      = 32'(cxq3_q) + 32'(pb3_q);
    wsum    = 32'(pa3_q) + 32'(item3_q.cx);
    raddr_a = mono ? ba[AW+1:2] : wsum[AW-1:0];
    raddr_b = bb[AW+1:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= s_valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && en3) begin
      item3_q <= s_item_i;
      pa3_q   <= pa_d;
      pb3_q   <= pb_d;
      cxq3_q  <= cxq_d;
    end
    if (fire3) begin
      item4_q   <= item3_q;
      lane_a4_q <= ba[1:0];
      lane_b4_q <= bb[1:0];
      bit4_q    <= item3_q.cx[2:0];
    end
  end

  // Loads write at the same stage where pixels read, so order is kept.
  cov_ram #(
    .WIDTH(32),
    .DEPTH(SHAPE_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (fire3 && item3_q.wr),
    .waddr_i  (AW'(item3_q.waddr)),
    .wdata_i  (item3_q.wdata),
    .re_i     (fire3),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(m_word_a_o),
    .rdata_b_o(m_word_b_o)
  );

endmodule
`default_nettype wire

FILE: rtl/cov_blend.sv
// Pixel composition: mask logic, masked-color xor and alpha blend, then the result register.
`timescale 1ns / 1ps
`default_nettype none
module cov_blend import cov_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire item_t       s_item_i,
  input  wire logic [1:0]  s_lane_a_i,
  input  wire logic [1:0]  s_lane_b_i,
  input  wire logic [2:0]  s_bit_i,
  input  wire logic [31:0] s_word_a_i,
  input  wire logic [31:0] s_word_b_i,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output res_t             m_res_o,
  output logic [31:0]      m_pixel_o
);

  logic        v5_q, v6_q, en5, en6;
  logic [7:0]  byte_a, byte_b, alpha, inv_alpha;
  logic        am, xm, is_alpha;
  logic [31:0] pre_d, pre5_q, pix6_q, pix_d;
  logic [15:0] sum_d [3];
  logic [15:0] sum5_q [3];
  logic [7:0]  quo [3];
  logic [16:0] tmp [3];
  logic [7:0]  desk_a5_q;
  logic        compose5_q, alpha5_q;
  res_t        res5_q, res6_q;

  assign en6       = !v6_q || m_ready_i;
  assign en5       = !v5_q || en6;
  assign s_ready_o = en5;
  assign m_valid_o = v6_q;
  assign m_res_o   = res6_q;
  assign m_pixel_o = pix6_q;

  always_comb begin
    byte_a    = s_word_a_i[{s_lane_a_i, 3'b000} +: 8];
    byte_b    = s_word_b_i[{s_lane_b_i, 3'b000} +: 8];
    am        = byte_a[3'd7 - s_bit_i];
    xm        = byte_b[3'd7 - s_bit_i];
    alpha     = s_word_a_i[31:24];
    inv_alpha = 8'd255 - alpha;
    is_alpha  = 1'b0;
    unique case (cfg_i.cursor_type)
      CT_MONO:   pre_d = (s_item_i.desk & {32{am}}) ^ {32{xm}};
      CT_ALPHA: begin
        pre_d    = s_item_i.desk;
        is_alpha = 1'b1;
      end
      CT_MASKED: begin
        if (s_word_a_i[31:24] != 8'd0) pre_d = (s_item_i.desk ^ s_word_a_i) | ALPHA_OPAQUE;
        else pre_d = s_word_a_i | ALPHA_OPAQUE;
      end
      default:   pre_d = s_item_i.desk;
    endcase
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = 16'(s_word_a_i[8*i +: 8]) * 16'(alpha) +
                 16'(s_item_i.desk[8*i +: 8]) * 16'(inv_alpha);
    end
  end

  // Exact floor division by 255 for sums below 65280.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tmp[i] = 17'(sum5_q[i]) + 17'd1 + 17'(sum5_q[i] >> 8);
      quo[i] = tmp[i][15:8];
    end
    if (!compose5_q) pix_d = '0;
    else if (alpha5_q) pix_d = {desk_a5_q, quo[2], quo[1], quo[0]};
    else pix_d = pre5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= s_valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && en5) begin
      res5_q     <= s_item_i.res;
      compose5_q <= s_item_i.compose;
      alpha5_q   <= is_alpha;
      pre5_q     <= pre_d;
      desk_a5_q  <= s_item_i.desk[31:24];
      for (int i = 0; i < 3; i++) sum5_q[i] <= sum_d[i];
    end
    if (v5_q && en6) begin
      res6_q <= res5_q;
      pix6_q <= pix_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cursor_overlay_compositor.sv
// Top level of the cursor overlay compositor: configuration registers and the pipeline.
//
// Channel   Direction  tdata / tuser / tlast
// s_axis    in         shape_addr, shape_data, pointer_x, pointer_y, desktop_pixel / action
// m_axis    out        pixel_out, box fields, status / result_kind / last_pixel
// cfg       in         write enable, register index, data
//
// One beat in and one beat out per cycle while the output is not stalled; each beat passes every stage.
// The stages are input register, coordinates, row products, store read, blend products
// and the result register. Stalls on the output ripple back stage by stage, so bubbles close.
// Reset clears valid bits and frame state and loads the configuration defaults; the shape store is
// not cleared and a word reads as garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none
module cursor_overlay_compositor import cov_pkg::*; #(
  parameter int unsigned SHAPE_WORDS = SHAPE_WORDS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_IW-1:0]  cfg_index_i,
  input  wire logic [CFG_DW-1:0]  cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // [11:0] shape_addr, [43:12] shape_data, [57:44] pointer_x, [71:58] pointer_y,
  // [103:72] desktop_pixel
  input  wire logic [103:0]       s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]         s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [31:0] pixel_out, [44:32] box_left, [57:45] box_top, [71:58] box_width,
  // [85:72] box_height, [87:86] status
  output logic [87:0]             m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]              m_axis_tuser,
  output logic                    m_axis_tlast
);

  cfg_t        cfg_q;
  logic        v2, r2, v4, r4;
  item_t       item2, item4;
  logic [1:0]  lane_a, lane_b;
  logic [2:0]  bit_sel;
  logic [31:0] word_a, word_b, pixel;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation      <= ROT_0;
      cfg_q.cursor_type   <= CT_ALPHA;
      cfg_q.cursor_width  <= 9'd32;
      cfg_q.shape_height  <= 10'd32;
      cfg_q.shape_pitch   <= 11'd128;
      cfg_q.screen_width  <= 14'd1920;
      cfg_q.screen_height <= 14'd1080;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_ROTATION:      cfg_q.rotation      <= rot_e'(cfg_data_i[1:0]);
        REG_CURSOR_TYPE:   cfg_q.cursor_type   <= ctype_e'(cfg_data_i[1:0]);
        REG_CURSOR_WIDTH:  cfg_q.cursor_width  <= cfg_data_i[8:0];
        REG_SHAPE_HEIGHT:  cfg_q.shape_height  <= cfg_data_i[9:0];
        REG_SHAPE_PITCH:   cfg_q.shape_pitch   <= cfg_data_i[10:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cov_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .action_i       (action_e'(s_axis_tuser)),
    .shape_addr_i   (s_axis_tdata[11:0]),
    .shape_data_i   (s_axis_tdata[43:12]),
    .pointer_x_i    ($signed(s_axis_tdata[57:44])),
    .pointer_y_i    ($signed(s_axis_tdata[71:58])),
    .desktop_pixel_i(s_axis_tdata[103:72]),
    .m_valid_o      (v2),
    .m_ready_i      (r2),
    .m_item_o       (item2)
  );

  cov_addr #(
    .SHAPE_WORDS(SHAPE_WORDS)
  ) u_addr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (v2),
    .s_ready_o (r2),
    .s_item_i  (item2),
    .m_valid_o (v4),
    .m_ready_i (r4),
    .m_item_o  (item4),
    .m_lane_a_o(lane_a),
    .m_lane_b_o(lane_b),
    .m_bit_o   (bit_sel),
    .m_word_a_o(word_a),
    .m_word_b_o(word_b)
  );

  cov_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (v4),
    .s_ready_o (r4),
    .s_item_i  (item4),
    .s_lane_a_i(lane_a),
    .s_lane_b_i(lane_b),
    .s_bit_i   (bit_sel),
    .s_word_a_i(word_a),
    .s_word_b_i(word_b),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res),
    .m_pixel_o (pixel)
  );

  assign m_axis_tdata = {res.status, res.box_height, res.box_width, res.box_top,
                         res.box_left, pixel};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

FILE: tb/sv/tb_cursor_overlay_compositor.sv
// Testbench for the cursor overlay compositor: stream stimulus, prediction and result checks.
`timescale 1ns / 1ps
module tb_cursor_overlay_compositor;
  import cov_pkg::*;

  // Every shape word that a pixel can reach under the configurations below lies in this range.
  localparam int FILL_WORDS = 512;

  typedef struct {
    kind_e       kind;
    logic [31:0] pix;
    logic [12:0] left;
    logic [12:0] top;
    logic [13:0] wid;
    logic [13:0] hgt;
    status_e     status;
    logic        last;
  } overlay_beat_t;

  // Predicts every result beat of the compositor and checks the beats that come out.
  class overlay_predictor;
    logic [31:0] shape_mem [SHAPE_WORDS_DEF];
    logic [1:0]  rotation;
    logic [1:0]  cursor_type;
    int          cursor_width, shape_height, shape_pitch, screen_width, screen_height;
    int          origin_left, origin_top, skip_cols, skip_rows;
    int          region_width, region_height, col_count, row_count;
    bit          frame_active;
    overlay_beat_t expected_beats[$];
    int          errors;

    function new();
      rotation = ROT_0; cursor_type = CT_ALPHA; cursor_width = 32; shape_height = 32;
      shape_pitch = 128; screen_width = 1920; screen_height = 1080;
      origin_left = 0; origin_top = 0; skip_cols = 0; skip_rows = 0;
      region_width = 0; region_height = 0; col_count = 0; row_count = 0;
      frame_active = 0; errors = 0;
    endfunction

    function void set_reg(reg_e idx, int val);
      case (idx)
        REG_ROTATION:      rotation = val[1:0];
        REG_CURSOR_TYPE:   cursor_type = val[1:0];
        REG_CURSOR_WIDTH:  cursor_width = val & 'h1FF;
        REG_SHAPE_HEIGHT:  shape_height = val & 'h3FF;
        REG_SHAPE_PITCH:   shape_pitch = val & 'h7FF;
        REG_SCREEN_WIDTH:  screen_width = val & 'h3FFF;
        REG_SCREEN_HEIGHT: screen_height = val & 'h3FFF;
        default: ;
      endcase
    endfunction

    function int image_rows();
      return (cursor_type == CT_MONO) ? shape_height / 2 : shape_height;
    endfunction

    function logic [7:0] shape_byte(longint baddr);
      logic [63:0] u;
      logic [31:0] w;
      u = baddr;
      w = shape_mem[u[13:2]];
      return w >> (8 * u[1:0]);
    endfunction

    function logic [31:0] compose(logic [31:0] desk, int x, int y);
      longint cw, ch, ox, oy, cx, cy;
      logic [63:0] ua;
      logic [7:0] bitm, am, xm;
      logic [31:0] cur, res;
      int c, d, a;
      cw = cursor_width; ch = image_rows();
      ox = x + skip_cols; oy = y + skip_rows;
      case (rotation)
        ROT_90:  begin cx = (cw - 1) - oy; cy = ox; end
        ROT_180: begin cx = (cw - 1) - ox; cy = (ch - 1) - oy; end
        ROT_270: begin cx = oy; cy = (ch - 1) - ox; end
        default: begin cx = ox; cy = oy; end
      endcase
      case (cursor_type)
        CT_MONO: begin
          ua = cx;
          bitm = 8'h80 >> ua[2:0];
          am = shape_byte(cx / 8 + cy * shape_pitch) & bitm;
          xm = shape_byte(cx / 8 + (cy + ch) * shape_pitch) & bitm;
          return (desk & ((am != 0) ? 32'hFFFF_FFFF : 32'h0)) ^
                 ((xm != 0) ? 32'hFFFF_FFFF : 32'h0);
        end
        CT_ALPHA, CT_MASKED: begin
          ua = cy * cw + cx;
          cur = shape_mem[ua[11:0]];
          if (cursor_type == CT_MASKED)
            return (cur[31:24] != 0) ? ((desk ^ cur) | ALPHA_OPAQUE) : (cur | ALPHA_OPAQUE);
          a = cur[31:24];
          res = desk & ALPHA_OPAQUE;
          for (int s = 0; s < 24; s += 8) begin
            c = (cur >> s) & 8'hFF;
            d = (desk >> s) & 8'hFF;
            res |= ((c * a + d * (255 - a)) / 255) << s;
          end
          return res;
        end
        default: return desk;
      endcase
    endfunction

    function void begin_frame(int px, int py, ref overlay_beat_t e);
      bit portrait;
      int cw, ch, capw, caph, dw, dh, dx, dy, offx, offy, left, top, right, bottom;
      portrait = rotation[0];
      cw = cursor_width; ch = image_rows();
      capw = portrait ? ch : cw; caph = portrait ? cw : ch;
      dw = portrait ? screen_height : screen_width;
      dh = portrait ? screen_width : screen_height;
      offx = 0; offy = 0;
      case (rotation)
        ROT_90:  begin dx = py; dy = (dh - 1) - px - cw; end
        ROT_180: begin dx = (dw - 1) - px - cw; dy = (dh - 1) - py - ch; end
        ROT_270: begin dx = (dw - 1) - py - ch; dy = px; end
        default: begin dx = px; dy = py; end
      endcase
      left = dx; top = dy; right = dx + capw; bottom = dy + caph;
      if (left < 0) begin capw += dx; offx = -dx; left = 0; end
      if (right > dw) capw -= right - dw;
      if (top < 0) begin caph += dy; offy = -dy; top = 0; end
      if (bottom > dh) caph -= bottom - dh;
      col_count = 0; row_count = 0;
      e.kind = KIND_BOX;
      if (capw <= 0 || caph <= 0) begin
        frame_active = 0;
        origin_left = 0; origin_top = 0; skip_cols = 0; skip_rows = 0;
        region_width = 0; region_height = 0;
        e.status = ST_EMPTY;
        return;
      end
      frame_active = 1;
      origin_left = left; origin_top = top; skip_cols = offx; skip_rows = offy;
      region_width = capw; region_height = caph;
      e.left = left; e.top = top; e.wid = capw; e.hgt = caph;
    endfunction

    function void note_item(action_e act, logic [11:0] addr, logic [31:0] data,
                            logic signed [13:0] px, logic signed [13:0] py,
                            logic [31:0] desk);
      overlay_beat_t e;
      e = '{KIND_LOAD, 32'h0, 13'h0, 13'h0, 14'h0, 14'h0, ST_OK, 1'b0};
      case (act)
        ACT_LOAD: shape_mem[addr] = data;
        ACT_FRAME: begin_frame(px, py, e);
        ACT_PIXEL: begin
          e.kind = KIND_PIXEL;
          if (!frame_active) e.status = ST_NOFRAME;
          else begin
            e.pix = compose(desk, col_count, row_count);
            col_count++;
            if (col_count >= region_width) begin
              col_count = 0;
              row_count++;
              if (row_count >= region_height) begin
                row_count = 0;
                frame_active = 0;
                e.last = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      expected_beats.push_back(e);
    endfunction

    function void check_beat(logic [1:0] kind, logic [87:0] data, logic last);
      overlay_beat_t e;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat kind %0d data %h", $time, kind, data);
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      if (kind != e.kind) begin
        $display("%0t: kind exp %0d act %0d", $time, e.kind, kind); errors++;
      end
      if (data[31:0] != e.pix) begin
        $display("%0t: pixel exp %h act %h", $time, e.pix, data[31:0]); errors++;
      end
      if (data[44:32] != e.left) begin
        $display("%0t: box_left exp %0d act %0d", $time, e.left, data[44:32]); errors++;
      end
      if (data[57:45] != e.top) begin
        $display("%0t: box_top exp %0d act %0d", $time, e.top, data[57:45]); errors++;
      end
      if (data[71:58] != e.wid) begin
        $display("%0t: box_width exp %0d act %0d", $time, e.wid, data[71:58]); errors++;
      end
      if (data[85:72] != e.hgt) begin
        $display("%0t: box_height exp %0d act %0d", $time, e.hgt, data[85:72]); errors++;
      end
      if (data[87:86] != e.status) begin
        $display("%0t: status exp %0d act %0d", $time, e.status, data[87:86]); errors++;
      end
      if (last != e.last) begin
        $display("%0t: last exp %0d act %0d", $time, e.last, last); errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [103:0]      s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [87:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;

  overlay_predictor overlay = new();
  bit calm = 0;
  int n_loads, n_frames, n_pixels, n_phases;

  always #5 clk_i = ~clk_i;

  cursor_overlay_compositor u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        overlay.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // Call at a rising edge; returns at the edge where the beat was taken.
  task automatic send_item(action_e act, logic [11:0] addr, logic [31:0] data,
                           logic [13:0] px, logic [13:0] py, logic [31:0] desk);
    while (!calm && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {desk, py, px, data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    overlay.note_item(act, addr, data, px, py, desk);
    case (act)
      ACT_LOAD:  n_loads++;
      ACT_FRAME: n_frames++;
      ACT_PIXEL: n_pixels++;
      default: ;
    endcase
  endtask

  task automatic load_word(int addr);
    send_item(ACT_LOAD, addr, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic frame_at(int px, int py);
    send_item(ACT_FRAME, $urandom, $urandom, px, py, $urandom);
  endtask

  task automatic pixels(int count);
    repeat (count) send_item(ACT_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (overlay.expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    overlay.set_reg(idx, val);
  endtask

  task automatic configure(int rot, int ct, int cw, int sh, int pitch, int sw, int shh);
    drain();
    // An open frame would reach shape words outside the loaded range once the cursor
    // size changes, so it is closed by a box that lies wholly off the screen.
    if (overlay.frame_active) begin
      if (overlay.rotation == ROT_180) frame_at(8191, 8191);
      else frame_at(-8192, -8192);
      drain();
    end
    write_reg(REG_ROTATION, rot);
    write_reg(REG_CURSOR_TYPE, ct);
    write_reg(REG_CURSOR_WIDTH, cw);
    write_reg(REG_SHAPE_HEIGHT, sh);
    write_reg(REG_SHAPE_PITCH, pitch);
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, shh);
    n_phases++;
  endtask

  // A frame on or around the screen, sometimes anywhere, then all of its pixels for most small boxes.
  task automatic random_frame();
    int span, px, py, area;
    span = overlay.cursor_width + overlay.shape_height + 4;
    if ($urandom_range(9) == 0) begin
      px = $urandom; py = $urandom;
    end else begin
      px = $urandom_range(overlay.screen_width + span) - span / 2;
      py = $urandom_range(overlay.screen_height + span) - span / 2;
    end
    frame_at(px, py);
    area = overlay.region_width * overlay.region_height;
    if (area > 0 && area <= 96 && $urandom_range(9) != 0) pixels(area);
    else pixels($urandom_range(12));
  endtask

  initial begin
    int budget;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the low part of the store; no pixel below ever reads an unloaded word.
    for (int a = 0; a < FILL_WORDS; a++) load_word(a);

    // Directed part, first under reset settings, then under three other configurations.
    pixels(1);
    send_item(ACT_NOP, 12'hFFF, 32'hFFFF_FFFF, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF);
    frame_at(0, 0);
    pixels(3);
    frame_at(-5, -3);
    pixels(2);
    frame_at(14'sh2000, 14'sh2000);
    pixels(1);
    frame_at(14'sh1FFF, 14'sh1FFF);
    frame_at(1919, 1079);
    pixels(2);
    configure(ROT_90, CT_MONO, 4, 4, 1, 3, 3);
    frame_at(1, 0);
    pixels(5);
    configure(ROT_180, CT_MASKED, 16, 24, 64, 8192, 8192);
    frame_at(8000, 8000);
    pixels(4);
    configure(ROT_270, CT_PASS, 0, 0, 0, 1, 1);
    frame_at(0, 0);
    pixels(1);

    budget = 1250;
    while (budget > 0) begin
      case ($urandom_range(7))
        0: configure($urandom_range(3), $urandom_range(3), 16, 24, 64, 8192, 8192);
        1: configure($urandom_range(3), $urandom_range(3), $urandom_range(2),
                     $urandom_range(3), $urandom_range(1024), 1, 1);
        default: configure($urandom_range(3), $urandom_range(3), $urandom_range(12),
                           $urandom_range(24), $urandom_range(16),
                           $urandom_range(40, 1), $urandom_range(40, 1));
      endcase
      calm = (budget < 900 && budget > 600);
      repeat ($urandom_range(10, 3)) begin
        budget -= 1 - n_pixels;
        case ($urandom_range(9))
          0: load_word($urandom);
          1: pixels(1);
          2: send_item(ACT_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
          default: random_frame();
        endcase
        budget -= n_pixels;
      end
    end
    calm = 0;

    drain();
    $display("Covered %0d phases: %0d loads, %0d frames, %0d pixels.",
             n_phases, n_loads, n_frames, n_pixels);
    $display("All rotations and cursor kinds, clipping, empty boxes and stray pixels were run.");
    if (overlay.errors == 0 && overlay.expected_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d beats outstanding.", overlay.expected_beats.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
